// ===== hw/rtl/srnd_pkg.sv =====
// types and constants shared by the sparse row drop filter
package srnd_pkg;

	localparam int VALUE_W = 32;
	localparam int INDEX_W = 20;
	localparam int KCNT_W  = 7;
	localparam int THR_W   = 7;
	localparam int TOL_W   = 16;

	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] CFG_COLOR_THRESHOLD = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_DROP_TOL        = 1'd1;

	localparam logic [THR_W-1:0] COLOR_THRESHOLD_RST = 7'd5;
	localparam logic [TOL_W-1:0] DROP_TOL_RST        = 16'd1311;

	typedef struct packed {
		logic signed [VALUE_W-1:0] entry_value;
		logic [INDEX_W-1:0]        col_index;
		logic [INDEX_W-1:0]        row_index;
		logic                      has_entry;
		logic                      row_last;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] kept_value;
		logic [INDEX_W-1:0]        kept_col;
		logic [INDEX_W-1:0]        kept_row;
		logic                      entry_valid;
		logic                      row_end;
		logic [KCNT_W-1:0]         row_kept_count;
	} out_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] col;
	} buf_entry_t;

endpackage

// ===== hw/rtl/srnd_row_buf.sv =====
// row buffer: one write port, one registered read port
module srnd_row_buf
	import srnd_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  buf_entry_t               wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output buf_entry_t               rd_data
);

	buf_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/sparse_row_norm_drop_filter.sv =====
// top level of the sparse row drop filter
// The block takes one matrix row at a time as a stream of items and gives
// back the row's surviving entries in arrival order. While a row is being
// collected an item is taken in every cycle: each entry goes into the row
// buffer and through a two-stage magnitude/square pipeline into a saturating
// 64-bit square sum, and off-diagonal entries are counted. Entries beyond
// ROW_MAX in one row are ignored. The item flagged row_last closes the row;
// no new item is taken until the row has been emitted. Closing runs through
// pipeline drain, tolerance square, two 32x32 partial products of sum
// times tolerance squared, and the threshold add; then the scan reads the
// row buffer one entry at a time (buffer read, magnitude, square, compare),
// the compare waiting while a kept entry cannot be pushed to a busy result
// side, and a final flush step puts out the last result. A long row keeps an
// entry when its square exceeds the row's square sum times drop_tol squared,
// drop_tol read as an unsigned 0.16 fraction; a short row keeps all entries;
// a row that keeps nothing gives one marker result.
// Configuration is written through cfg_wr_en / cfg_addr / cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
module sparse_row_norm_drop_filter
	import srnd_pkg::*;
#(
	parameter int ROW_MAX = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  in_item_t              item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output out_item_t             result,
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int IDX_W = $clog2(ROW_MAX);
	localparam int CNT_W = $clog2(ROW_MAX + 1);
	localparam int LW    = ((CNT_W > THR_W) ? CNT_W : THR_W) + 1;

	// sequencer codes
	localparam logic [3:0] ST_COLLECT = 4'd0;
	localparam logic [3:0] ST_DRAIN1  = 4'd1;
	localparam logic [3:0] ST_DRAIN2  = 4'd2;
	localparam logic [3:0] ST_PROD0   = 4'd3;
	localparam logic [3:0] ST_PROD1   = 4'd4;
	localparam logic [3:0] ST_THR     = 4'd5;
	localparam logic [3:0] ST_RD      = 4'd6;
	localparam logic [3:0] ST_MAG     = 4'd7;
	localparam logic [3:0] ST_SQ      = 4'd8;
	localparam logic [3:0] ST_CMP     = 4'd9;
	localparam logic [3:0] ST_FLUSH   = 4'd10;

	// configuration
	logic [THR_W-1:0] color_thr_q;
	logic [TOL_W-1:0] drop_tol_q;

	// control state
	logic [3:0]       state_q;
	logic [CNT_W-1:0] entry_cnt_q;
	logic [CNT_W-1:0] offdiag_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] kept_cnt_q;
	logic             pend_vld_q;
	logic             long_q;
	logic             vld_s1;
	logic             vld_s2;
	logic [63:0]      sum_q;

	// payload registers
	logic [31:0]      mag_s1;
	logic [63:0]      sq_s2;
	logic [INDEX_W-1:0] row_q;
	logic [31:0]      t2_q;
	logic [63:0]      p0_q;
	logic [63:0]      p1_q;
	logic [63:0]      thr_q;
	logic [31:0]      mag_q;
	logic [63:0]      sq_q;
	buf_entry_t       pend_q;

	// row buffer ports
	logic             buf_wr;
	buf_entry_t       buf_wdata;
	buf_entry_t       buf_rdata;
	logic             buf_rd;

	// output register
	logic             out_vld_q;
	out_item_t        out_q;

	logic             accept;
	logic             take;
	logic             out_free;
	logic             keep;
	logic             last_idx;
	logic [64:0]      sum_ext;
	logic [LW-1:0]    od_plus;
	logic             flush_done;
	logic             cmp_adv;
	logic             cmp_push;

	// magnitude of a two's complement word, min value gives 2^31
	function automatic logic [31:0] abs32(input logic [31:0] raw);
		abs32 = raw[31] ? (~raw + 32'd1) : raw;
	endfunction

	assign item_ready = (state_q == ST_COLLECT);
	assign accept     = item_valid && item_ready;
	assign take       = accept && item.has_entry && (entry_cnt_q < CNT_W'(ROW_MAX));

	assign out_free   = !out_vld_q || result_ready;
	assign keep       = !long_q || (sq_q > thr_q);
	assign last_idx   = ((idx_q + CNT_W'(1)) == entry_cnt_q);
	assign sum_ext    = {1'b0, sum_q} + {1'b0, sq_s2};
	assign od_plus    = LW'(offdiag_q) + LW'(1);
	assign flush_done = (state_q == ST_FLUSH) && out_free;

	// a kept entry with one already pending pushes the pending one out first
	assign cmp_push   = (state_q == ST_CMP) && keep && pend_vld_q;
	assign cmp_adv    = (state_q == ST_CMP) && (!cmp_push || out_free);

	assign buf_wr     = take;
	assign buf_wdata  = '{value: item.entry_value, col: item.col_index};
	assign buf_rd     = (state_q == ST_RD);

	srnd_row_buf #(
		.DEPTH(ROW_MAX)
	) u_row_buf (
		.clk     (clk),
		.wr_en   (buf_wr),
		.wr_addr (entry_cnt_q[IDX_W-1:0]),
		.wr_data (buf_wdata),
		.rd_en   (buf_rd),
		.rd_addr (idx_q[IDX_W-1:0]),
		.rd_data (buf_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_thr_q <= COLOR_THRESHOLD_RST;
			drop_tol_q  <= DROP_TOL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				CFG_COLOR_THRESHOLD: color_thr_q <= cfg_wdata[THR_W-1:0];
				CFG_DROP_TOL:        drop_tol_q  <= cfg_wdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			entry_cnt_q <= '0;
			offdiag_q   <= '0;
			idx_q       <= '0;
			kept_cnt_q  <= '0;
			pend_vld_q  <= 1'b0;
			long_q      <= 1'b0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			sum_q       <= '0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;

			// saturating square sum, cleared when the row is done
			if (flush_done) begin
				sum_q <= '0;
			end else if (vld_s2) begin
				sum_q <= sum_ext[64] ? '1 : sum_ext[63:0];
			end

			if (take) begin
				entry_cnt_q <= entry_cnt_q + CNT_W'(1);
				if (item.col_index != item.row_index) begin
					offdiag_q <= offdiag_q + CNT_W'(1);
				end
			end

			case (state_q)
				ST_COLLECT: begin
					if (accept && item.row_last) begin
						state_q <= ST_DRAIN1;
					end
				end
				ST_DRAIN1: begin
					long_q  <= (od_plus >= LW'(color_thr_q));
					state_q <= ST_DRAIN2;
				end
				ST_DRAIN2: state_q <= ST_PROD0;
				ST_PROD0:  state_q <= ST_PROD1;
				ST_PROD1:  state_q <= ST_THR;
				ST_THR: begin
					idx_q   <= '0;
					state_q <= (entry_cnt_q == '0) ? ST_FLUSH : ST_RD;
				end
				ST_RD:  state_q <= ST_MAG;
				ST_MAG: state_q <= ST_SQ;
				ST_SQ:  state_q <= ST_CMP;
				ST_CMP: begin
					if (cmp_adv) begin
						if (keep) begin
							pend_vld_q <= 1'b1;
							kept_cnt_q <= kept_cnt_q + CNT_W'(1);
						end
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= last_idx ? ST_FLUSH : ST_RD;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						entry_cnt_q <= '0;
						offdiag_q   <= '0;
						kept_cnt_q  <= '0;
						pend_vld_q  <= 1'b0;
						state_q     <= ST_COLLECT;
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

	// datapath: square pipeline, threshold product, scan
	always_ff @(posedge clk) begin
		mag_s1 <= abs32(item.entry_value);
		sq_s2  <= 64'(mag_s1) * 64'(mag_s1);

		if (accept && item.row_last) begin
			row_q <= item.row_index;
		end
		if (state_q == ST_DRAIN1) begin
			t2_q <= 32'(drop_tol_q) * 32'(drop_tol_q);
		end
		if (state_q == ST_PROD0) begin
			p0_q <= 64'(sum_q[31:0]) * 64'(t2_q);
		end
		if (state_q == ST_PROD1) begin
			p1_q <= 64'(sum_q[63:32]) * 64'(t2_q);
		end
		// upper 64 bits of sum * t2; the low word cannot tip the compare
		if (state_q == ST_THR) begin
			thr_q <= p1_q + {32'd0, p0_q[63:32]};
		end
		if (state_q == ST_MAG) begin
			mag_q <= abs32(buf_rdata.value);
		end
		if (state_q == ST_SQ) begin
			sq_q <= 64'(mag_q) * 64'(mag_q);
		end
		if (cmp_adv && keep) begin
			pend_q <= buf_rdata;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmp_push && out_free) begin
			out_vld_q <= 1'b1;
		end else if (flush_done) begin
			out_vld_q <= 1'b1;
		end else if (result_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_push && out_free) begin
			out_q.kept_value     <= pend_q.value;
			out_q.kept_col       <= pend_q.col;
			out_q.kept_row       <= row_q;
			out_q.entry_valid    <= 1'b1;
			out_q.row_end        <= 1'b0;
			out_q.row_kept_count <= '0;
		end else if (flush_done) begin
			out_q.kept_row <= row_q;
			out_q.row_end  <= 1'b1;
			if (pend_vld_q) begin
				out_q.kept_value     <= pend_q.value;
				out_q.kept_col       <= pend_q.col;
				out_q.entry_valid    <= 1'b1;
				out_q.row_kept_count <= KCNT_W'(kept_cnt_q);
			end else begin
				// empty row marker
				out_q.kept_value     <= '0;
				out_q.kept_col       <= '0;
				out_q.entry_valid    <= 1'b0;
				out_q.row_kept_count <= '0;
			end
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

`ifndef SYNTHESIS
	a_count_only_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.row_end |-> result.row_kept_count == '0)
		else $error("kept count on a result that does not end its row");

	a_marker_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.entry_valid |-> result.row_end)
		else $error("empty row marker without row end");

	a_entry_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q <= CNT_W'(ROW_MAX) && offdiag_q <= entry_cnt_q)
		else $error("row buffer count out of range");

	a_kept_le_entries: assert property (@(posedge clk) disable iff (!arst_n)
		kept_cnt_q <= entry_cnt_q)
		else $error("more entries kept than buffered");

	a_row_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.row_last |=> !item_ready)
		else $error("item taken while a row is being closed");
`endif

endmodule
